// ----- rtl/cbx_pkg.sv -----
package cbx_pkg;

	localparam int KEY_LENGTH = 15;
	localparam int KEY_IDX_W = $clog2(KEY_LENGTH);
	localparam int KEY_W = 8 * KEY_LENGTH;
	localparam int KEY_LOW_W = 64;
	localparam int KEY_HIGH_W = KEY_W - KEY_LOW_W;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd2;

	localparam logic [KEY_IDX_W-1:0] KEY_IDX_LAST = KEY_IDX_W'(KEY_LENGTH - 1);

	typedef logic [7:0] byte_t;
	typedef logic [KEY_IDX_W-1:0] key_idx_t;

	function automatic byte_t key_byte(input logic [KEY_W-1:0] key, input key_idx_t idx);
		byte_t b;
		b = '0;
		for (int i = 0; i < KEY_LENGTH; i++) begin
			if (idx == KEY_IDX_W'(i)) begin
				b = key[8*i +: 8];
			end
		end
		return b;
	endfunction

endpackage

// ----- rtl/chained_byte_xor_cipher.sv -----
// Chained byte cipher with a 15-byte key. One byte enters per transaction on the
// input channel and one transformed byte leaves per transaction on the output
// channel, with end_of_message copied to result_last. The transform is computed
// in the cycle the byte is accepted and held in an output register, so a byte is
// accepted every cycle while the output side keeps taking results.
// start_of_message clears position, key index and the chaining byte before its
// byte is processed. Key and mode registers are written through the configuration
// channel (index 0 key bytes 0..7, 1 key bytes 8..14, 2 mode: 1 encrypt, 0 decrypt);
// the user must write them only while no byte is in flight, and the block does not
// enforce this; cfg_ready is always high and writes to other indexes are ignored.
module chained_byte_xor_cipher (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cbx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbx_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       data_byte,
	input  logic                             start_of_message,
	input  logic                             end_of_message,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       result_byte,
	output logic                             result_last
);

	logic [cbx_pkg::KEY_LOW_W-1:0]  key_low_q;
	logic [cbx_pkg::KEY_HIGH_W-1:0] key_high_q;
	logic                           encrypt_q;

	cbx_pkg::byte_t    chain_q;
	cbx_pkg::byte_t    pos_q;
	cbx_pkg::key_idx_t key_idx_q;

	logic              out_valid_q;
	cbx_pkg::byte_t    result_q;
	logic              last_q;

	logic              in_fire;
	cbx_pkg::byte_t    chain_eff;
	cbx_pkg::byte_t    pos_eff;
	cbx_pkg::key_idx_t key_idx_eff;
	cbx_pkg::byte_t    key_b;
	cbx_pkg::byte_t    res;
	cbx_pkg::byte_t    chain_next;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			encrypt_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == cbx_pkg::REG_KEY_LOW) begin
				key_low_q <= cfg_data;
			end
			if (cfg_index == cbx_pkg::REG_KEY_HIGH) begin
				key_high_q <= cfg_data[cbx_pkg::KEY_HIGH_W-1:0];
			end
			if (cfg_index == cbx_pkg::REG_MODE) begin
				encrypt_q <= cfg_data[0];
			end
		end
	end

	always_comb begin
		chain_eff = start_of_message ? '0 : chain_q;
		pos_eff = start_of_message ? '0 : pos_q;
		key_idx_eff = start_of_message ? '0 : key_idx_q;
		key_b = cbx_pkg::key_byte({key_high_q, key_low_q}, key_idx_eff);
		if (encrypt_q) begin
			res = ((chain_eff ^ data_byte) + pos_eff) ^ key_b;
			chain_next = res;
		end else begin
			res = ((data_byte ^ key_b) - pos_eff) ^ chain_eff;
			chain_next = data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			pos_q <= '0;
			key_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				chain_q <= chain_next;
				pos_q <= pos_eff + 8'd1;
				key_idx_q <= (key_idx_eff == cbx_pkg::KEY_IDX_LAST) ? '0
					: key_idx_eff + cbx_pkg::KEY_IDX_W'(1);
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			result_q <= res;
			last_q <= end_of_message;
		end
	end

	assign out_valid = out_valid_q;
	assign result_byte = result_q;
	assign result_last = last_q;

endmodule

// ----- rtl/cbx_checker.sv -----
module cbx_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_ready,
	input logic in_valid,
	input logic in_ready,
	input logic end_of_message,
	input logic out_valid,
	input logic out_ready,
	input logic result_last
);

	// a pending result that is not taken stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	// input side free whenever the output register is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output register");

	// every accepted byte shows up next cycle with its last flag
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid && (result_last == $past(end_of_message)))
		else $error("accepted transaction missing or wrong last flag");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind chained_byte_xor_cipher cbx_checker u_cbx_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cfg_ready(cfg_ready),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.end_of_message(end_of_message),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.result_last(result_last)
);
